@@ hw/rtl/gbh_pkg.sv @@
// shared types and constants of the 3x3 blur / high-pass filter
package gbh_pkg;

  localparam int PIX_W   = 8;
  localparam int CH      = 3;
  localparam int WORD_W  = CH * PIX_W;
  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int WGT_W   = 12;
  localparam int FRAC    = 12;
  localparam int SUM_W   = 24;
  localparam int SAT     = 255;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;
  localparam int NJOBS   = 4;

  // result kinds per input pixel, in output order
  localparam int JOB_ABOVE_LEFT = 0;
  localparam int JOB_ABOVE_END  = 1;
  localparam int JOB_LAST_LEFT  = 2;
  localparam int JOB_LAST_END   = 3;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_FILTER_MODE   = 3'd3,
    REG_WEIGHT_CENTER = 3'd4,
    REG_WEIGHT_EDGE   = 3'd5,
    REG_WEIGHT_CORNER = 3'd6
  } reg_idx_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [1:0]       active;
    logic             mode;
    logic [WGT_W-1:0] w_ctr;
    logic [WGT_W-1:0] w_edge;
    logic [WGT_W-1:0] w_crn;
  } cfg_t;

  typedef struct packed {
    word_t [2:0][2:0]   taps;
    logic               left_rep;
    logic [NJOBS-1:0]   jobs;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              stage_b;
  } fe_stat_t;

endpackage

@@ hw/rtl/gbh_ifs.sv @@
// pixel and result channel interfaces
interface gbh_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_c0;
  logic [7:0] pixel_c1;
  logic [7:0] pixel_c2;
  modport source (output valid, pixel_c0, pixel_c1, pixel_c2, input ready);
  modport sink (input valid, pixel_c0, pixel_c1, pixel_c2, output ready);
endinterface

interface gbh_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_c0;
  logic [7:0] out_c1;
  logic [7:0] out_c2;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic       frame_last;
  modport source (output valid, out_c0, out_c1, out_c2, out_row, out_col, frame_last,
                  input ready);
  modport sink (input valid, out_c0, out_c1, out_c2, out_row, out_col, frame_last,
                output ready);
endinterface

@@ hw/rtl/gbh_queue.sv @@
// short queue of classified windows between front and back
module gbh_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gbh_pkg::entry_t push_data,
  input  logic            pop,
  output gbh_pkg::entry_t head,
  output logic            nonempty,
  output logic [gbh_pkg::QCNT_W-1:0] level
);
  import gbh_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head     = slots[rd_ptr];
  assign nonempty = level != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

@@ hw/rtl/gbh_front.sv @@
// front end: raster counters, line stores, window and result classification
module gbh_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  gbh_pixel_if.sink         pixels,
  input  gbh_pkg::cfg_t     cfg,
  input  logic [gbh_pkg::QCNT_W-1:0] level,
  output logic              push,
  output gbh_pkg::entry_t   push_data,
  output gbh_pkg::fe_stat_t stat
);
  import gbh_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  logic                end_row;
  logic                last_row;
  logic                accept;
  logic [QCNT_W:0]     pending;
  logic [NJOBS-1:0]    jobs;

  logic                b_valid;
  word_t               b_pix;
  logic [COORD_W-1:0]  b_row;
  logic [COORD_W-1:0]  b_col;
  logic [NJOBS-1:0]    b_jobs;
  logic                b_top_edge;
  logic                b_oob;
  logic [AW-1:0]       b_addr;

  logic [2*WORD_W-1:0] lines [MAX_WIDTH];
  logic [2*WORD_W-1:0] rd_data;
  word_t               up_w;
  word_t               mid_w;
  word_t               top_w;
  word_t [2:0][2:0]    win;
  word_t [2:0][2:0]    win_next;

  assign end_row  = {1'b0, col} >= (cfg.width_eff - DIM_W'(1));
  assign last_row = {1'b0, row} >= (cfg.height_eff - DIM_W'(1));
  assign pending  = {1'b0, level} + (QCNT_W+1)'(b_valid);
  assign pixels.ready = pending < (QCNT_W+1)'(QDEPTH);
  assign accept   = pixels.valid && pixels.ready;

  always_comb begin
    jobs = '0;
    jobs[JOB_ABOVE_LEFT] = (row != '0) && (col != '0);
    jobs[JOB_ABOVE_END]  = (row != '0) && end_row;
    jobs[JOB_LAST_LEFT]  = (row != '0) && last_row && (col != '0);
    jobs[JOB_LAST_END]   = (row != '0) && last_row && end_row;
  end

  // line store word: previous-but-one row above, previous row below
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= lines[AW'(col)];
    end
    if (b_valid && !b_oob) begin
      lines[b_addr] <= {rd_data[WORD_W-1:0], b_pix};
    end
  end

  assign up_w  = b_oob ? '0 : rd_data[2*WORD_W-1:WORD_W];
  assign mid_w = b_oob ? '0 : rd_data[WORD_W-1:0];
  assign top_w = b_top_edge ? mid_w : up_w;

  always_comb begin
    win_next       = win;
    win_next[0]    = win[1];
    win_next[1]    = win[2];
    win_next[2][0] = top_w;
    win_next[2][1] = mid_w;
    win_next[2][2] = b_pix;
  end

  assign push               = b_valid && (b_jobs != '0);
  assign push_data.taps     = win_next;
  assign push_data.left_rep = b_col == COORD_W'(1);
  assign push_data.jobs     = b_jobs;
  assign push_data.row      = b_row;
  assign push_data.col      = b_col;

  assign stat.level   = level;
  assign stat.stage_b = b_valid;

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix      <= {pixels.pixel_c2, pixels.pixel_c1, pixels.pixel_c0};
      b_row      <= row;
      b_col      <= col;
      b_jobs     <= jobs;
      b_top_edge <= row == COORD_W'(1);
      b_oob      <= 32'(col) >= MAX_WIDTH;
      b_addr     <= AW'(col);
    end
    if (rst) begin
      b_valid <= 1'b0;
      row     <= '0;
      col     <= '0;
      win     <= '0;
    end else begin
      b_valid <= accept;
      if (b_valid) begin
        win <= win_next;
      end
      if (accept) begin
        if (end_row) begin
          col <= '0;
          row <= last_row ? '0 : row + COORD_W'(1);
        end else begin
          col <= col + COORD_W'(1);
        end
      end
    end
  end

endmodule

@@ hw/rtl/gbh_back.sv @@
// back end: per-result tap selection, weighted sums and output register
module gbh_back #(
  parameter int LANES = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  gbh_pkg::entry_t head,
  input  logic            nonempty,
  input  gbh_pkg::cfg_t   cfg,
  output logic            pop,
  gbh_result_if.source    results
);
  import gbh_pkg::*;

  logic [NJOBS-1:0]   done;
  logic [NJOBS-1:0]   left;
  logic [NJOBS-1:0]   sel;
  logic [NJOBS-1:0]   rest;
  logic               near;
  logic               bottom;
  logic [1:0]         ca, cb, cd, rt, rm, ru;
  logic               out_free;
  logic               s1_ready;
  logic               issue;

  logic               s1_valid;
  logic [SUM_W-1:0]   s1_sum [CH];
  logic [PIX_W-1:0]   s1_ctr [CH];
  logic [CH-1:0]      s1_on;
  logic [COORD_W-1:0] s1_row;
  logic [COORD_W-1:0] s1_col;
  logic               s1_last;

  logic [SUM_W-1:0]   sum_c [CH];
  logic [PIX_W-1:0]   ctr_c [CH];
  logic [PIX_W-1:0]   res_c [CH];
  logic [CH-1:0]      lane_on;

  assign left   = head.jobs & ~done;
  assign sel    = left & (~left + NJOBS'(1));
  assign rest   = left & ~sel;
  assign near   = sel[JOB_ABOVE_LEFT] | sel[JOB_LAST_LEFT];
  assign bottom = sel[JOB_LAST_LEFT] | sel[JOB_LAST_END];
  assign ca = near ? (head.left_rep ? 2'd1 : 2'd0) : 2'd1;
  assign cb = near ? 2'd1 : 2'd2;
  assign cd = 2'd2;
  assign rt = bottom ? 2'd1 : 2'd0;
  assign rm = bottom ? 2'd2 : 2'd1;
  assign ru = 2'd2;

  assign out_free = !results.valid || results.ready;
  assign s1_ready = !s1_valid || out_free;
  assign issue    = nonempty && s1_ready;
  assign pop      = issue && (rest == '0);

  for (genvar k = 0; k < CH; k++) begin : g_lane
    assign lane_on[k] = (k < LANES) && (32'(cfg.active) > k);
    if (k < LANES) begin : g_on
      logic [PIX_W-1:0]   ctr;
      logic [PIX_W+1:0]   edges;
      logic [PIX_W+1:0]   corners;
      logic [SUM_W-1:0]   p_ctr, p_edge, p_crn;
      logic [SUM_W-FRAC-1:0] lp_raw;
      logic [PIX_W-1:0]   lp;
      logic [PIX_W:0]     diff;
      assign ctr     = head.taps[cb][rm][k*PIX_W +: PIX_W];
      assign edges   = (PIX_W+2)'(head.taps[cb][rt][k*PIX_W +: PIX_W])
                     + (PIX_W+2)'(head.taps[cb][ru][k*PIX_W +: PIX_W])
                     + (PIX_W+2)'(head.taps[ca][rm][k*PIX_W +: PIX_W])
                     + (PIX_W+2)'(head.taps[cd][rm][k*PIX_W +: PIX_W]);
      assign corners = (PIX_W+2)'(head.taps[ca][rt][k*PIX_W +: PIX_W])
                     + (PIX_W+2)'(head.taps[ca][ru][k*PIX_W +: PIX_W])
                     + (PIX_W+2)'(head.taps[cd][rt][k*PIX_W +: PIX_W])
                     + (PIX_W+2)'(head.taps[cd][ru][k*PIX_W +: PIX_W]);
      assign p_ctr   = SUM_W'(cfg.w_ctr) * SUM_W'(ctr);
      assign p_edge  = SUM_W'(cfg.w_edge) * SUM_W'(edges);
      assign p_crn   = SUM_W'(cfg.w_crn) * SUM_W'(corners);
      assign sum_c[k] = p_ctr + p_edge + p_crn;
      assign ctr_c[k] = ctr;
      // second stage: truncate, saturate, optional doubled difference
      assign lp_raw = s1_sum[k][SUM_W-1:FRAC];
      assign lp     = (lp_raw > (SUM_W-FRAC)'(SAT)) ? PIX_W'(SAT) : lp_raw[PIX_W-1:0];
      assign diff   = (s1_ctr[k] > lp) ? {1'b0, s1_ctr[k] - lp} : {1'b0, lp - s1_ctr[k]};
      always_comb begin
        if (!s1_on[k]) begin
          res_c[k] = '0;
        end else if (cfg.mode) begin
          res_c[k] = (diff > (PIX_W+1)'(SAT >> 1)) ? PIX_W'(SAT) : {diff[PIX_W-2:0], 1'b0};
        end else begin
          res_c[k] = lp;
        end
      end
    end else begin : g_off
      assign sum_c[k] = '0;
      assign ctr_c[k] = '0;
      assign res_c[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sum  <= sum_c;
      s1_ctr  <= ctr_c;
      s1_on   <= lane_on;
      s1_row  <= bottom ? head.row : head.row - COORD_W'(1);
      s1_col  <= near ? head.col - COORD_W'(1) : head.col;
      s1_last <= sel[JOB_LAST_END];
    end
    if (s1_valid && out_free) begin
      results.out_c0     <= res_c[0];
      results.out_c1     <= res_c[1];
      results.out_c2     <= res_c[2];
      results.out_row    <= s1_row;
      results.out_col    <= s1_col;
      results.frame_last <= s1_last;
    end
    if (rst) begin
      done          <= '0;
      s1_valid      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (issue) begin
        done <= pop ? '0 : (done | sel);
      end
      if (s1_ready) begin
        s1_valid <= issue;
      end
      if (out_free) begin
        results.valid <= s1_valid;
      end
    end
  end

endmodule

@@ hw/rtl/gaussian_blur_highpass_filter.sv @@
// top level: configuration registers, front end, window queue and back end
// Streaming 3x3 blur / high-pass filter with replicated borders. One pixel is
// taken per clock while the queue has room. A pixel in the first row or at the
// start of a row yields no result, an interior pixel one, a pixel that ends a
// row or lies in the last row two, and the final pixel of the frame four. The
// back end sends one result per clock unless stalled, so the input keeps one pixel
// per clock except through the last row, where it slows to about half rate while
// the window queue drains. Results pass the line store stage, queue, sum and
// output registers, one row and one column behind the input. The line stores are
// a single read port / write port memory of MAX_WIDTH words and need no clearing
// after reset. Registers may only be written while the block is idle.
module gaussian_blur_highpass_filter #(
  parameter int MAX_WIDTH = 1024,
  parameter int LANES     = 3
) (
  input  logic        clk,
  input  logic        rst,
  gbh_pixel_if.sink   pixels,
  gbh_result_if.source results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gbh_pkg::*;

  localparam int WMAX = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int LCAP = (LANES < CH) ? LANES : CH;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [1:0]       channel_count;
  logic             filter_mode;
  logic [WGT_W-1:0] weight_center;
  logic [WGT_W-1:0] weight_edge;
  logic [WGT_W-1:0] weight_corner;

  cfg_t              cfg;
  reg_idx_t          reg_sel;
  logic              wr_en;
  logic              push;
  entry_t            push_data;
  entry_t            head;
  logic              nonempty;
  logic              pop;
  logic [QCNT_W-1:0] level;
  fe_stat_t          fe_stat;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DIM_W'(1024);
      image_height  <= DIM_W'(1024);
      channel_count <= 2'd3;
      filter_mode   <= 1'b0;
      weight_center <= WGT_W'(1024);
      weight_edge   <= WGT_W'(512);
      weight_corner <= WGT_W'(256);
    end else if (wr_en) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:   image_width   <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= pwdata[DIM_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[1:0];
        REG_FILTER_MODE:   filter_mode   <= pwdata[0];
        REG_WEIGHT_CENTER: weight_center <= pwdata[WGT_W-1:0];
        REG_WEIGHT_EDGE:   weight_edge   <= pwdata[WGT_W-1:0];
        REG_WEIGHT_CORNER: weight_corner <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:   prdata = 32'(image_width);
      REG_IMAGE_HEIGHT:  prdata = 32'(image_height);
      REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      REG_FILTER_MODE:   prdata = 32'(filter_mode);
      REG_WEIGHT_CENTER: prdata = 32'(weight_center);
      REG_WEIGHT_EDGE:   prdata = 32'(weight_edge);
      REG_WEIGHT_CORNER: prdata = 32'(weight_corner);
      default:           prdata = '0;
    endcase
  end

  // clamped working values
  always_comb begin
    if (image_width < DIM_W'(2)) begin
      cfg.width_eff = DIM_W'(2);
    end else if (image_width > DIM_W'(WMAX)) begin
      cfg.width_eff = DIM_W'(WMAX);
    end else begin
      cfg.width_eff = image_width;
    end
    if (image_height < DIM_W'(2)) begin
      cfg.height_eff = DIM_W'(2);
    end else if (image_height > DIM_W'(1024)) begin
      cfg.height_eff = DIM_W'(1024);
    end else begin
      cfg.height_eff = image_height;
    end
    if (channel_count == 2'd0) begin
      cfg.active = 2'd1;
    end else if (channel_count > 2'(LCAP)) begin
      cfg.active = 2'(LCAP);
    end else begin
      cfg.active = channel_count;
    end
    cfg.mode   = filter_mode;
    cfg.w_ctr  = weight_center;
    cfg.w_edge = weight_edge;
    cfg.w_crn  = weight_corner;
  end

  gbh_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg       (cfg),
    .level     (level),
    .push      (push),
    .push_data (push_data),
    .stat      (fe_stat)
  );

  gbh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty),
    .level     (level)
  );

  gbh_back #(
    .LANES(LANES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .nonempty (nonempty),
    .cfg      (cfg),
    .pop      (pop),
    .results  (results)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fe_stat.level <= QCNT_W'(QDEPTH))
    else $error("window queue over capacity");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (fe_stat.level == QCNT_W'(QDEPTH)) |-> !pixels.ready)
    else $error("input taken while queue full");

  a_stage_follows: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready) |=> fe_stat.stage_b)
    else $error("accepted item lost before line store stage");

endmodule

@@ test/tb_gaussian_blur_highpass_filter.sv @@
// self-checking testbench of the 3x3 blur / high-pass filter with replicated borders
module tb_gaussian_blur_highpass_filter;
  import gbh_pkg::*;

  typedef struct {
    logic [7:0] c [3];
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } px_result_t;

  typedef enum int {DIR_UNIFORM, DIR_HIGHPASS, DIR_SAT, DIR_CLAMP} dir_phase_t;

  typedef struct {
    dir_phase_t phase;
    logic [7:0] c0, c1, c2;
    bit         chk;
    logic [7:0] expv;
  } dir_row_t;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  gbh_pixel_if  pix ();
  gbh_result_if res ();

  gaussian_blur_highpass_filter dut (
    .clk(clk), .rst(rst), .pixels(pix), .results(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // filter model state
  logic [DIM_W-1:0] m_width, m_height;
  logic [1:0]       m_chan;
  logic             m_mode;
  logic [WGT_W-1:0] m_wc, m_we, m_wk;
  logic [23:0]      line_up [1024];
  logic [23:0]      line_lo [1024];
  logic [23:0]      win [9];
  int               in_row, in_col;

  px_result_t exp_q [$];
  int         errors;
  bit         calm, gap_on;
  int         hold_left, stall_n;
  bit         cur_chk;
  logic [7:0] cur_exp;

  dir_row_t dir_tab [20] = '{
    '{DIR_UNIFORM, 255, 255, 255, 1, 255}, '{DIR_UNIFORM, 255, 255, 255, 1, 255},
    '{DIR_UNIFORM, 255, 255, 255, 1, 255}, '{DIR_UNIFORM, 255, 255, 255, 1, 255},
    '{DIR_UNIFORM, 0, 0, 0, 1, 0},         '{DIR_UNIFORM, 0, 0, 0, 1, 0},
    '{DIR_UNIFORM, 0, 0, 0, 1, 0},         '{DIR_UNIFORM, 0, 0, 0, 1, 0},
    '{DIR_HIGHPASS, 128, 7, 200, 1, 0},    '{DIR_HIGHPASS, 128, 7, 200, 1, 0},
    '{DIR_HIGHPASS, 128, 7, 200, 1, 0},    '{DIR_HIGHPASS, 128, 7, 200, 1, 0},
    '{DIR_SAT, 255, 255, 255, 1, 255},     '{DIR_SAT, 255, 255, 255, 1, 255},
    '{DIR_SAT, 255, 255, 255, 1, 255},     '{DIR_SAT, 255, 255, 255, 1, 255},
    '{DIR_CLAMP, 10, 200, 33, 0, 0},       '{DIR_CLAMP, 255, 0, 170, 0, 0},
    '{DIR_CLAMP, 85, 255, 1, 0, 0},        '{DIR_CLAMP, 0, 128, 254, 0, 0}
  };

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("[gaussian_blur_highpass_filter] ERROR");
    $finish;
  end

  function automatic logic [7:0] lane(logic [23:0] word, int k);
    return word[8*k +: 8];
  endfunction

  function automatic px_result_t blur_at(int a, int b, int d, int t, int m, int u,
                                         int row, int col, bit last, int act);
    px_result_t r;
    int ctr, edges, corners, sum, lp, v;
    for (int k = 0; k < 3; k++) begin
      v = 0;
      if (k < act) begin
        ctr = lane(win[b*3+m], k);
        edges = lane(win[b*3+t], k) + lane(win[b*3+u], k)
              + lane(win[a*3+m], k) + lane(win[d*3+m], k);
        corners = lane(win[a*3+t], k) + lane(win[a*3+u], k)
                + lane(win[d*3+t], k) + lane(win[d*3+u], k);
        sum = m_wc * ctr + m_we * edges + m_wk * corners;
        lp = sum >> FRAC;
        if (lp > SAT) lp = SAT;
        if (m_mode) begin
          v = 2 * ((ctr > lp) ? ctr - lp : lp - ctr);
          if (v > SAT) v = SAT;
        end else begin
          v = lp;
        end
      end
      r.c[k] = v[7:0];
    end
    r.row = row[9:0];
    r.col = col[9:0];
    r.last = last;
    return r;
  endfunction

  task automatic push_result(px_result_t r, bit chk, logic [7:0] expv, int act);
    exp_q.push_back(r);
    if (chk) begin
      for (int k = 0; k < 3; k++) begin
        if (r.c[k] !== ((k < act) ? expv : 8'd0)) begin
          $display("%0t lane %0d table value: expected %0d actual %0d",
                   $time, k, (k < act) ? expv : 8'd0, r.c[k]);
          errors++;
        end
      end
    end
  endtask

  task automatic filter_step(logic [23:0] pw, bit chk, logic [7:0] expv);
    int w, h, act, r, c;
    bit end_row, last_row;
    logic [23:0] top, mid;
    r = in_row;
    c = in_col;
    w = m_width;
    if (w < 2) w = 2;
    if (w > 1024) w = 1024;
    h = m_height;
    if (h < 2) h = 2;
    if (h > 1024) h = 1024;
    act = (m_chan == 0) ? 1 : m_chan;
    end_row = c >= w - 1;
    last_row = r >= h - 1;
    top = line_up[c];
    mid = line_lo[c];
    line_up[c] = mid;
    line_lo[c] = pw;
    if (r == 1) top = mid;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = top;
    win[7] = mid;
    win[8] = pw;
    if (r >= 1) begin
      if (c >= 1)
        push_result(blur_at((c == 1) ? 1 : 0, 1, 2, 0, 1, 2, r - 1, c - 1, 0, act),
                    chk, expv, act);
      if (end_row) push_result(blur_at(1, 2, 2, 0, 1, 2, r - 1, c, 0, act), chk, expv, act);
      if (last_row) begin
        if (c >= 1)
          push_result(blur_at((c == 1) ? 1 : 0, 1, 2, 1, 2, 2, r, c - 1, 0, act),
                      chk, expv, act);
        if (end_row) push_result(blur_at(1, 2, 2, 1, 2, 2, r, c, 1, act), chk, expv, act);
      end
    end
    if (end_row) begin
      in_col = 0;
      in_row = last_row ? 0 : ((r + 1) & 10'h3FF);
    end else begin
      in_col = (c + 1) & 10'h3FF;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pix.valid && pix.ready)
      filter_step({pix.pixel_c2, pix.pixel_c1, pix.pixel_c0}, cur_chk, cur_exp);
  end

  always @(posedge clk) begin
    px_result_t e;
    if (!rst && res.valid && res.ready) begin
      if (exp_q.size() == 0) begin
        $display("%0t unexpected item: row %0d col %0d", $time, res.out_row, res.out_col);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (res.out_c0 !== e.c[0] || res.out_c1 !== e.c[1] || res.out_c2 !== e.c[2] ||
            res.out_row !== e.row || res.out_col !== e.col || res.frame_last !== e.last) begin
          $display("%0t mismatch: expected %0d %0d %0d r%0d c%0d l%0d actual %0d %0d %0d r%0d c%0d l%0d",
                   $time, e.c[0], e.c[1], e.c[2], e.row, e.col, e.last,
                   res.out_c0, res.out_c1, res.out_c2, res.out_row, res.out_col,
                   res.frame_last);
          errors++;
        end
      end
    end
  end

  initial begin
    res.ready = 0;
    stall_n = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res.ready = 0;
        hold_left--;
      end else if (stall_n > 0) begin
        res.ready = 0;
        stall_n--;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        res.ready = 0;
        stall_n = $urandom_range(1, 13) - 1;
      end else begin
        res.ready = 1;
      end
    end
  end

  task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] d,
                            bit chk, logic [7:0] expv);
    int n;
    if (gap_on && !calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      pix.valid = 0;
      repeat (n) @(negedge clk);
    end
    pix.valid = 1;
    pix.pixel_c0 = a;
    pix.pixel_c1 = b;
    pix.pixel_c2 = d;
    cur_chk = chk;
    cur_exp = expv;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  task automatic send_noise();
    logic [7:0] v [3];
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 7))
        0: v[k] = 8'd0;
        1: v[k] = 8'd255;
        default: v[k] = 8'($urandom_range(0, 255));
      endcase
    send_pixel(v[0], v[1], v[2], 0, 0);
  endtask

  task automatic drain();
    pix.valid = 0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0;
    penable = 0;
    case (idx)
      REG_IMAGE_WIDTH:   m_width = v[10:0];
      REG_IMAGE_HEIGHT:  m_height = v[10:0];
      REG_CHANNEL_COUNT: m_chan = v[1:0];
      REG_FILTER_MODE:   m_mode = v[0];
      REG_WEIGHT_CENTER: m_wc = v[11:0];
      REG_WEIGHT_EDGE:   m_we = v[11:0];
      REG_WEIGHT_CORNER: m_wk = v[11:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int w, int h, int ch, int md, int wc, int we, int wk);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_CHANNEL_COUNT, ch);
    reg_write(REG_FILTER_MODE, md);
    reg_write(REG_WEIGHT_CENTER, wc);
    reg_write(REG_WEIGHT_EDGE, we);
    reg_write(REG_WEIGHT_CORNER, wk);
  endtask

  function automatic int rand_weight();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(0, 4095);
      default: return $urandom_range(100, 1200);
    endcase
  endfunction

  initial begin
    int sent, w, h, cw, ch_;
    dir_phase_t ph;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    pix.valid = 0; pix.pixel_c0 = 0; pix.pixel_c1 = 0; pix.pixel_c2 = 0;
    m_width = 1024; m_height = 1024; m_chan = 3; m_mode = 0;
    m_wc = 1024; m_we = 512; m_wk = 256;
    foreach (line_up[i]) begin
      line_up[i] = 0;
      line_lo[i] = 0;
    end
    foreach (win[i]) win[i] = 0;
    in_row = 0; in_col = 0;
    errors = 0; calm = 0; gap_on = 1; hold_left = 0;
    cur_chk = 0; cur_exp = 0;
    repeat (11) @(negedge clk);
    rst = 0;

    // directed table, config changes at phase boundaries
    for (int i = 0; i < 20; i++) begin
      if (i == 0 || dir_tab[i].phase != ph) begin
        ph = dir_tab[i].phase;
        drain();
        case (ph)
          DIR_UNIFORM:  set_all(2, 2, 3, 0, 1024, 512, 256);
          DIR_HIGHPASS: set_all(2, 2, 3, 1, 1024, 512, 256);
          DIR_SAT:      set_all(2, 2, 3, 0, 4095, 4095, 4095);
          DIR_CLAMP:    set_all(1, 0, 0, 0, 1024, 512, 256);
          default: ;
        endcase
      end
      send_pixel(dir_tab[i].c0, dir_tab[i].c1, dir_tab[i].c2, dir_tab[i].chk,
                 dir_tab[i].expv);
    end

    // shrink width and height in the middle of a frame
    drain();
    set_all(8, 6, 2, 1, 2048, 300, 100);
    repeat (19) send_noise();
    drain();
    reg_write(REG_IMAGE_WIDTH, 4);
    reg_write(REG_IMAGE_HEIGHT, 2);
    repeat (9) send_noise();

    // oversized width, then oversized height, each cut short by a shrink
    drain();
    set_all(2047, 0, 3, 0, 1024, 512, 256);
    gap_on = 0;
    repeat (40) send_noise();
    drain();
    reg_write(REG_IMAGE_WIDTH, 20);
    repeat (21) send_noise();
    drain();
    set_all(0, 2047, 3, 1, 1500, 400, 200);
    repeat (40) send_noise();
    drain();
    reg_write(REG_IMAGE_HEIGHT, 2);
    repeat (2) send_noise();

    // long receiver hold while the sender keeps offering
    drain();
    set_all(6, 10, 3, 0, 1024, 512, 256);
    hold_left = 300;
    repeat (60) send_noise();

    // random frames
    sent = 0;
    while (sent < 120) begin
      drain();
      if ($urandom_range(0, 5) == 0) begin
        w = $urandom_range(20, 40);
        h = 2;
      end else begin
        w = $urandom_range(2, 10);
        h = $urandom_range(2, 6);
      end
      cw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : w;
      ch_ = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : h;
      set_all(cw, ch_, $urandom_range(0, 3), $urandom_range(0, 1),
              rand_weight(), rand_weight(), rand_weight());
      if (cw < 2) w = 2;
      if (ch_ < 2) h = 2;
      gap_on = $urandom_range(0, 2) != 0;
      if (sent > 60) calm = 1;
      repeat (w * h) send_noise();
      sent += w * h;
    end

    pix.valid = 0;
    calm = 1;
    w = 0;
    while (exp_q.size() != 0 && w < 200000) begin
      @(posedge clk);
      w++;
    end
    repeat (20) @(posedge clk);
    if (exp_q.size() != 0) begin
      $display("%0t %0d expected items never arrived", $time, exp_q.size());
      errors++;
    end
    if (errors == 0)
      $display("[gaussian_blur_highpass_filter] OK");
    else
      $display("[gaussian_blur_highpass_filter] ERROR");
    $finish;
  end

endmodule
